// ===== design/fcrc_pkg.sv =====
// shared types, codes and the crc step function for the framed crc16 block
package fcrc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h8005;
    localparam logic [BYTE_W-1:0] MIN_LEN  = 8'd3;

    // frame status codes
    localparam logic [1:0] FS_PROGRESS = 2'd0;
    localparam logic [1:0] FS_GOOD     = 2'd1;
    localparam logic [1:0] FS_BAD_CRC  = 2'd2;
    localparam logic [1:0] FS_BAD_LEN  = 2'd3;

    // result kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_CRC  = 1'b1;

    // frame mode codes
    localparam logic MODE_GEN   = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    typedef struct packed {
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] pos;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] crc_lo;
    } t_frame_state;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_kind;
        logic [1:0]        status;
        logic              eof;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]             cnt;
        t_result [MAX_RES-1:0]        res;
    } t_bundle;

    function automatic t_result mk_result(logic [BYTE_W-1:0] b, logic kind,
                                          logic [1:0] status, logic eof);
        t_result r;
        r.out_byte = b;
        r.out_kind = kind;
        r.status   = status;
        r.eof      = eof;
        return r;
    endfunction

    // one byte into the crc, lsb first, left-shifting register
    function automatic logic [CRC_W-1:0] crc_feed(logic [CRC_W-1:0] crc_in,
                                                  logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = b[i] ^ c[CRC_W-1];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/fcrc_frame_proc.sv =====
// per-byte frame logic: next frame state and the result beats for one byte
module fcrc_frame_proc import fcrc_pkg::*; (
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_mode,
    input  t_frame_state      i_state,
    output t_frame_state      o_state,
    output t_bundle           o_bundle
);

    logic [CRC_W-1:0]  crc_base;
    logic [CRC_W-1:0]  crc_fed;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] lo_base;
    logic              first;
    logic              good;

    assign first   = (i_state.pos == '0);
    assign len     = first ? i_byte : i_state.len;
    assign crc_base = first ? '0 : i_state.crc;
    assign lo_base = first ? '0 : i_state.crc_lo;
    assign crc_fed = crc_feed(crc_base, i_byte);
    assign good    = (crc_base[7:0] == lo_base) && (crc_base[15:8] == i_byte);

    always_comb begin
        o_state        = i_state;
        o_bundle       = '0;
        if (first && (i_byte < MIN_LEN)) begin
            // bad length byte closes the frame at once
            o_state         = '0;
            o_bundle.cnt    = CNT_W'(1);
            o_bundle.res[0] = mk_result(i_byte, KIND_DATA, FS_BAD_LEN, 1'b1);
        end else begin
            o_state.len    = len;
            o_state.crc    = crc_base;
            o_state.crc_lo = lo_base;
            o_bundle.res[0] = mk_result(i_byte, KIND_DATA, FS_PROGRESS, 1'b0);
            o_bundle.cnt    = CNT_W'(1);
            if (i_mode == MODE_GEN) begin
                o_state.crc = crc_fed;
                if (i_state.pos >= (len - MIN_LEN)) begin
                    o_state.pos     = '0;
                    o_bundle.cnt    = CNT_W'(3);
                    o_bundle.res[1] = mk_result(crc_fed[7:0], KIND_CRC, FS_PROGRESS, 1'b0);
                    o_bundle.res[2] = mk_result(crc_fed[15:8], KIND_CRC, FS_GOOD, 1'b1);
                end else begin
                    o_state.pos = i_state.pos + 8'd1;
                end
            end else begin
                if (i_state.pos >= (len - 8'd1)) begin
                    o_state.pos     = '0;
                    o_bundle.res[0] = mk_result(i_byte, KIND_DATA,
                                                good ? FS_GOOD : FS_BAD_CRC, 1'b1);
                end else begin
                    if (i_state.pos == (len - 8'd2)) begin
                        o_state.crc_lo = i_byte;
                    end else begin
                        o_state.crc = crc_fed;
                    end
                    o_state.pos = i_state.pos + 8'd1;
                end
            end
        end
    end

endmodule

// ===== design/framed_crc16_append_check_unit.sv =====
// top level of the framed crc16 append / check block
//
// input channel: one frame byte per beat on i_data_byte, i_data_valid / o_data_ready.
// the first byte of a frame is its total length, counting itself and two crc bytes.
// output channel: one result per beat (o_out_byte, o_out_kind, o_frame_status,
// o_end_of_frame) on o_result_valid / i_result_ready.
// config: i_cfg_we writes i_cfg_wdata into frame_mode (0 generate, 1 check);
// the user must write it only while the block is idle; the block does not enforce this.
// a byte taken into the input register moves into the result register once that
// register is empty or emptying; slot 0 of the result register is on the port.
// throughput: one byte per cycle while the receiver takes every beat; in generate
// mode the last data byte of a frame yields three result beats, which the single
// output port drains from the result register; the next byte loads only as the last leaves.
// a stalled receiver holds the result register; one more byte still lands in the
// input register before o_data_ready drops.
// reset: frame state, crc, frame_mode and both valid flags clear; the block
// then awaits a length byte.
module framed_crc16_append_check_unit import fcrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_data_valid,
    output logic              o_data_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_result_valid,
    input  logic              i_result_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_kind,
    output logic [1:0]        o_frame_status,
    output logic              o_end_of_frame
);

    logic                   r_frame_mode;
    logic                   r_in_vld;
    logic [BYTE_W-1:0]      r_in_byte;
    t_frame_state           r_state;
    t_frame_state           n_state;
    t_bundle                n_bundle;
    logic [CNT_W-1:0]       r_res_cnt;
    t_result [MAX_RES-1:0]  r_res;
    logic                   w_pop;
    logic                   w_load;
    logic                   w_take;

    // result beat leaves the output register
    assign w_pop  = o_result_valid && i_result_ready;
    // buffered byte moves into the result register once it is empty or emptying
    assign w_load = r_in_vld && ((r_res_cnt == '0) ||
                                 ((r_res_cnt == CNT_W'(1)) && i_result_ready));
    assign o_data_ready = !r_in_vld || w_load;
    assign w_take = i_data_valid && o_data_ready;

    fcrc_frame_proc u_proc (
        .i_byte   (r_in_byte),
        .i_mode   (r_frame_mode),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_bundle (n_bundle)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_mode <= MODE_GEN;
        end else if (i_cfg_we) begin
            r_frame_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    // frame state advances when a byte is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_load) begin
            r_state <= n_state;
        end
    end

    // result register: up to three beats, slot 0 is on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= '0;
        end else if (w_load) begin
            r_res_cnt <= n_bundle.cnt;
        end else if (w_pop) begin
            r_res_cnt <= r_res_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_bundle.res;
        end else if (w_pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_result_valid = (r_res_cnt != '0);
    assign o_out_byte     = r_res[0].out_byte;
    assign o_out_kind     = r_res[0].out_kind;
    assign o_frame_status = r_res[0].status;
    assign o_end_of_frame = r_res[0].eof;

    // last beat of a frame never reports in-progress status
    a_eof_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_end_of_frame) |-> (o_frame_status != FS_PROGRESS))
        else $error("frame end with in-progress status");

    // first appended crc byte always has the high byte queued behind it
    a_crc_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_out_kind == KIND_CRC) && !o_end_of_frame)
            |-> (r_res_cnt == CNT_W'(2)))
        else $error("crc low byte without queued high byte");

    // a loaded frame-ending bundle leaves the block awaiting a length byte
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_bundle.res[n_bundle.cnt - CNT_W'(1)].eof) |=> (r_state.pos == '0))
        else $error("position not cleared after frame end");

    // a load never overwrites beats still waiting to be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> ((r_res_cnt == '0) || ((r_res_cnt == CNT_W'(1)) && w_pop)))
        else $error("result register overwritten");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the framed crc16 append / check unit
module testbench import fcrc_pkg::*; ();

    // clock, reset and block ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic              i_cfg_wdata    = 1'b0;
    logic              i_data_valid   = 1'b0;
    logic [BYTE_W-1:0] i_data_byte    = '0;
    logic              i_result_ready = 1'b0;
    logic              o_data_ready;
    logic              o_result_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_out_kind;
    logic [1:0]        o_frame_status;
    logic              o_end_of_frame;

    framed_crc16_append_check_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_data_valid   (i_data_valid),
        .o_data_ready   (o_data_ready),
        .i_data_byte    (i_data_byte),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_out_byte     (o_out_byte),
        .o_out_kind     (o_out_kind),
        .o_frame_status (o_frame_status),
        .o_end_of_frame (o_end_of_frame)
    );

    // period of two time units
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bytes waiting for the driver, and results the framer still owes us
    logic [BYTE_W-1:0] tx_bytes[$];
    logic [BYTE_W-1:0] frame_buf[$];
    t_result           frame_results_due[$];

    int          bytes_queued  = 0;
    int          bytes_taken   = 0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int          ends_by_status[4];
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    int          rx_hold_left  = 0;
    logic        rx_hold_arm   = 1'b0;
    logic        data_beat     = 1'b0;

    // shadow of the framer: mode register plus frame state
    logic              mode_now    = MODE_GEN;
    logic [CRC_W-1:0]  run_crc     = '0;
    int                frame_pos   = 0;
    int                frame_len   = 0;
    logic [BYTE_W-1:0] held_crc_lo = '0;

    // one byte into the crc, bit 0 first, register shifting toward the msb
    function automatic logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1] ^ b[k]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    task automatic owe_result(input logic [BYTE_W-1:0] b, input logic kind,
                              input logic [1:0] status, input logic eof);
        t_result r;
        r.out_byte = b;
        r.out_kind = kind;
        r.status   = status;
        r.eof      = eof;
        frame_results_due.push_back(r);
    endtask

    // expected results for one accepted input byte
    task automatic crc_frame_predict(input logic [BYTE_W-1:0] b);
        int   pos;
        logic good;
        pos = frame_pos;
        if (pos == 0) begin
            // length byte: too short ends the frame right here
            if (b < MIN_LEN) begin
                owe_result(b, KIND_DATA, FS_BAD_LEN, 1'b1);
                run_crc     = '0;
                frame_len   = 0;
                held_crc_lo = '0;
                return;
            end
            frame_len   = b;
            run_crc     = '0;
            held_crc_lo = '0;
        end
        if (mode_now == MODE_GEN) begin
            run_crc = crc16_step(run_crc, b);
            owe_result(b, KIND_DATA, FS_PROGRESS, 1'b0);
            if (pos >= frame_len - 3) begin
                // last data byte: append crc low then high
                owe_result(run_crc[7:0], KIND_CRC, FS_PROGRESS, 1'b0);
                owe_result(run_crc[15:8], KIND_CRC, FS_GOOD, 1'b1);
                frame_pos = 0;
            end else begin
                frame_pos = pos + 1;
            end
        end else begin
            if (pos >= frame_len - 1) begin
                good = (run_crc[7:0] == held_crc_lo) && (run_crc[15:8] == b);
                owe_result(b, KIND_DATA, good ? FS_GOOD : FS_BAD_CRC, 1'b1);
                frame_pos = 0;
            end else begin
                if (pos == frame_len - 2) begin
                    held_crc_lo = b;
                end else begin
                    run_crc = crc16_step(run_crc, b);
                end
                owe_result(b, KIND_DATA, FS_PROGRESS, 1'b0);
                frame_pos = pos + 1;
            end
        end
    endtask

    task automatic flag_error(input string what, input t_result want);
        mismatches++;
        if (mismatches <= 10) begin
            $display("error %0d: %s: expected byte %02h kind %0d status %0d eof %0d,",
                     mismatches, what, want.out_byte, want.out_kind, want.status,
                     want.eof);
            $display("    got byte %02h kind %0d status %0d eof %0d",
                     o_out_byte, o_out_kind, o_frame_status, o_end_of_frame);
        end
    endtask

    // sample both channels at the rising edge; input beats feed the shadow first
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            data_beat = 1'b0;
        end else begin
            data_beat = i_data_valid && o_data_ready;
            if (data_beat) begin
                crc_frame_predict(i_data_byte);
                bytes_taken++;
            end
            if (o_result_valid && i_result_ready) begin
                results_seen++;
                if (frame_results_due.size() == 0) begin
                    want = '0;
                    flag_error("result beat with nothing owed", want);
                end else begin
                    want = frame_results_due.pop_front();
                    if (o_out_byte !== want.out_byte || o_out_kind !== want.out_kind ||
                        o_frame_status !== want.status || o_end_of_frame !== want.eof) begin
                        flag_error("result beat differs", want);
                    end
                    if (o_end_of_frame === 1'b1) begin
                        ends_by_status[o_frame_status]++;
                    end
                end
            end
        end
    end

    // sender: new beat at the falling edge once the previous one went through
    always @(negedge i_clk) begin
        logic              nv;
        logic [BYTE_W-1:0] nb;
        nv = i_data_valid;
        nb = i_data_byte;
        if (!i_data_valid || data_beat) begin
            nv = 1'b0;
            if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nv = 1'b1;
                nb = tx_bytes.pop_front();
            end
        end
        i_data_valid <= nv;
        i_data_byte  <= nb;
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(negedge i_clk) begin
        if (rx_hold_arm) begin
            rx_hold_left = 60;
            rx_hold_arm  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_result_ready <= 1'b0;
        end else begin
            i_result_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic offer_frame(input int keep);
        for (int k = 0; k < keep; k++) begin
            queue_byte(frame_buf[k]);
        end
    endtask

    // length byte, len-3 random data bytes, and for check form the crc pair
    task automatic build_frame(input int len, input logic check_form, input logic corrupt);
        logic [CRC_W-1:0] c;
        frame_buf.delete();
        frame_buf.push_back(len[7:0]);
        for (int k = 0; k < len - 3; k++) begin
            frame_buf.push_back(BYTE_W'($urandom_range(255)));
        end
        if (check_form) begin
            c = '0;
            foreach (frame_buf[k]) begin
                c = crc16_step(c, frame_buf[k]);
            end
            if (corrupt) begin
                c = c ^ (16'h0001 << $urandom_range(15));
            end
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(c[15:8]);
        end
    endtask

    // the sender pauses here until every byte is in and every result is out
    task automatic set_mode(input logic m);
        while (bytes_taken != bytes_queued || frame_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_now     = m;
    endtask

    // mostly well-formed frames of the current mode, some noise, maybe a cut-off tail
    task automatic random_phase(input logic m, input int tx_pct, input int rx_pct, input int n);
        int added;
        int pick;
        int len;
        added = 0;
        set_mode(m);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        while (added < n) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                len = $urandom_range(14, 3);
                build_frame(len, m, (m == MODE_CHECK) && ($urandom_range(4) == 0));
            end else if (pick < 76) begin
                len = $urandom_range(48, 15);
                build_frame(len, m, 1'b0);
            end else if (pick < 86) begin
                frame_buf.delete();
                frame_buf.push_back(BYTE_W'($urandom_range(2)));
            end else if (pick < 95) begin
                // frame shaped for the other mode
                len = $urandom_range(10, 3);
                build_frame(len, !m, 1'b0);
            end else begin
                frame_buf.delete();
                frame_buf.push_back(BYTE_W'($urandom_range(255)));
            end
            offer_frame(frame_buf.size());
            added += frame_buf.size();
        end
        // leave a frame half done so the next mode picks it up
        if ($urandom_range(1)) begin
            len = $urandom_range(14, 5);
            build_frame(len, m, 1'b0);
            offer_frame($urandom_range(frame_buf.size() - 1, 1));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // generate mode: short lengths, minimum frame, all-zero / all-one data
        set_mode(MODE_GEN);
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_byte(8'h02);
        queue_byte(8'h03);
        queue_byte(8'h05);
        queue_byte(8'h00);
        queue_byte(8'hFF);

        // check mode: good minimum frame, bad crc, short length, frame left open
        set_mode(MODE_CHECK);
        build_frame(3, 1'b1, 1'b0);
        offer_frame(frame_buf.size());
        build_frame(4, 1'b1, 1'b1);
        offer_frame(frame_buf.size());
        queue_byte(8'h02);
        queue_byte(8'h08);
        queue_byte(8'hA5);

        // open check frame finishes in generate mode with the crc appended
        set_mode(MODE_GEN);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h3C);
        queue_byte(8'h81);

        // crc low byte taken in check mode, then generate mode ends the frame at once
        set_mode(MODE_CHECK);
        queue_byte(8'h04);
        queue_byte(8'h5A);
        queue_byte(8'h12);
        set_mode(MODE_GEN);
        queue_byte(8'hC3);

        // random part; the first phase parks the receiver while bytes keep coming
        random_phase(MODE_GEN, 0, 0, 17);
        @(posedge i_clk);
        rx_hold_arm = 1'b1;
        random_phase(MODE_CHECK, 0, 0, 17);
        random_phase(MODE_GEN, 59, 0, 17);
        random_phase(MODE_CHECK, 59, 0, 17);
        random_phase(MODE_GEN, 0, 59, 17);
        random_phase(MODE_CHECK, 0, 59, 17);
        random_phase(MODE_GEN, 23, 23, 17);
        random_phase(MODE_CHECK, 23, 23, 17);

        // drain, then give a stray late beat time to show up
        while (bytes_taken != bytes_queued || frame_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("covered %0d input beats and %0d result beats across both modes",
                 bytes_taken, results_seen);
        $display("frame ends: %0d good/appended, %0d bad crc, %0d bad length; %0d errors",
                 ends_by_status[FS_GOOD], ends_by_status[FS_BAD_CRC],
                 ends_by_status[FS_BAD_LEN], mismatches);
        if (mismatches == 0 && frame_results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
